### hdl/tti_pkg.sv
// tti_pkg: shared widths, calibration tables and types of the thermistor
// table interpolator. No dependencies; used by tti_divider and the top level.
`default_nettype none

package tti_pkg;

  // field widths
  localparam int CODE_W   = 12;
  localparam int TEMP_W   = 17;
  localparam int STATUS_W = 2;
  localparam int PROD_W   = CODE_W + TEMP_W;

  // calibration table
  localparam int CAL_LEN = 32;
  localparam int SEG_W   = $clog2(CAL_LEN);

  // parameter defaults
  localparam int DEF_TABLE_SIZE = 32;
  localparam int DEF_ADC_BITS   = 12;

  // divider: quotient bits resolved per pipeline stage
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = (TEMP_W + DIV_STEPS - 1) / DIV_STEPS;

  // clamp temperatures in millidegrees
  localparam logic [TEMP_W-1:0] CLAMP_LOW_MDEG  = TEMP_W'(11999);
  localparam logic [TEMP_W-1:0] CLAMP_HIGH_MDEG = TEMP_W'(93999);

  // breakpoint converter codes, strictly falling
  localparam logic [CODE_W-1:0] CAL_CODE [CAL_LEN] = '{
    12'd2917, 12'd2890, 12'd2853, 12'd2816, 12'd2793, 12'd2754, 12'd2729, 12'd2692,
    12'd2569, 12'd2523, 12'd2488, 12'd2474, 12'd2454, 12'd2435, 12'd2349, 12'd2290,
    12'd2182, 12'd2087, 12'd2023, 12'd1928, 12'd1823, 12'd1783, 12'd1632, 12'd1531,
    12'd1452, 12'd1140, 12'd1002, 12'd914,  12'd856,  12'd821,  12'd703,  12'd613
  };

  // breakpoint temperatures in millidegrees, rising
  localparam logic [TEMP_W-1:0] CAL_MDEG [CAL_LEN] = '{
    17'd12600, 17'd13500, 17'd14630, 17'd15760, 17'd16500, 17'd17750, 17'd18500,
    17'd19500, 17'd23000, 17'd24400, 17'd25500, 17'd26000, 17'd26500, 17'd27120,
    17'd29660, 17'd31370, 17'd34540, 17'd37310, 17'd39140, 17'd41820, 17'd44990,
    17'd46660, 17'd50950, 17'd52190, 17'd56430, 17'd67870, 17'd73470, 17'd77000,
    17'd80010, 17'd81730, 17'd88030, 17'd93500
  };

  // range status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INTERP = 2'd0,
    ST_BELOW  = 2'd1,
    ST_ABOVE  = 2'd2
  } status_t;

  // sideband that rides along the divider pipeline
  typedef struct packed {
    logic              pass;   // result is base as is (clamp or empty segment)
    logic              up;     // add quotient to base, else subtract
    logic [TEMP_W-1:0] base;
    status_t           status;
  } side_t;

endpackage

`default_nettype wire

### hdl/thermistor_table_interpolator.sv
// thermistor_table_interpolator: converter sample to millidegrees by piecewise
// linear interpolation over a constant table. Depends on tti_pkg, tti_divider.
//
//  channel   ports                          direction  transaction
//  input     start, busy, adc_reading       in         start high, busy low
//  result    done, temp_millideg,           out        done high for one cycle
//            range_status
//
// One sample may be accepted every cycle; busy is always low.
// Pipeline: segment search, table lookup, multiply, six divider stages of up
// to three quotient bits each, and the output register.
// Synchronous reset clears the valid bits only; samples in flight are dropped.
// The receiver cannot stall, so results leave on a fixed schedule.
`default_nettype none

module thermistor_table_interpolator
  import tti_pkg::*;
#(
  parameter int TABLE_SIZE = DEF_TABLE_SIZE,
  parameter int ADC_BITS   = DEF_ADC_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CODE_W-1:0]   adc_reading,
  output logic                     done,
  output logic [TEMP_W-1:0]        temp_millideg,
  output logic [STATUS_W-1:0]      range_status
);

  localparam int USED_LEN  = (TABLE_SIZE < 2) ? 2 :
                             ((TABLE_SIZE < CAL_LEN) ? TABLE_SIZE : CAL_LEN);
  localparam int MASK_BITS = (ADC_BITS < CODE_W) ? ADC_BITS : CODE_W;
  localparam logic [CODE_W-1:0] X_MASK = CODE_W'((2 ** MASK_BITS) - 1);
  localparam int LATENCY   = 4 + DIV_STAGES;

  assign busy = 1'b0;

  // stage 1: range check and segment search
  logic [CODE_W-1:0] x;
  logic [SEG_W-1:0]  seg;
  status_t           st;

  always_comb begin
    x   = adc_reading & X_MASK;
    seg = '0;
    for (int j = USED_LEN - 1; j >= 1; j--) begin
      if (x >= CAL_CODE[j]) begin
        seg = SEG_W'(j - 1);
      end
    end
    priority if (x >= CAL_CODE[0]) begin
      st = ST_BELOW;
    end else if (x <= CAL_CODE[USED_LEN-1]) begin
      st = ST_ABOVE;
    end else begin
      st = ST_INTERP;
    end
  end

  logic              v1;
  logic [CODE_W-1:0] x1;
  logic [SEG_W-1:0]  seg1;
  status_t           st1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    x1   <= x;
    seg1 <= seg;
    st1  <= st;
  end

  // stage 2: breakpoint lookup, offset, spans and direction
  logic [SEG_W-1:0]  k1;
  logic [CODE_W-1:0] hi_code;
  logic [CODE_W-1:0] lo_code;
  logic [TEMP_W-1:0] lo_mdeg;
  logic [TEMP_W-1:0] hi_mdeg;
  logic [CODE_W-1:0] span;
  logic [CODE_W-1:0] off;
  logic [TEMP_W-1:0] mag;
  side_t             side_c;

  always_comb begin
    k1      = seg1 + SEG_W'(1);
    hi_code = CAL_CODE[seg1];
    lo_code = CAL_CODE[k1];
    lo_mdeg = CAL_MDEG[k1];
    hi_mdeg = CAL_MDEG[seg1];
    span    = hi_code - lo_code;
    off     = x1 - lo_code;
    side_c.up     = hi_mdeg > lo_mdeg;
    mag           = side_c.up ? (hi_mdeg - lo_mdeg) : (lo_mdeg - hi_mdeg);
    side_c.status = st1;
    unique case (st1)
      ST_BELOW: begin
        side_c.pass = 1'b1;
        side_c.base = CLAMP_LOW_MDEG;
      end
      ST_ABOVE: begin
        side_c.pass = 1'b1;
        side_c.base = CLAMP_HIGH_MDEG;
      end
      default: begin
        side_c.pass = (span == '0);
        side_c.base = lo_mdeg;
      end
    endcase
  end

  logic              v2;
  logic [CODE_W-1:0] off2;
  logic [CODE_W-1:0] span2;
  logic [TEMP_W-1:0] mag2;
  side_t             side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    off2  <= off;
    span2 <= span;
    mag2  <= mag;
    side2 <= side_c;
  end

  // stage 3: temperature span times offset
  logic              v3;
  logic [PROD_W-1:0] prod3;
  logic [CODE_W-1:0] span3;
  side_t             side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    prod3 <= {{CODE_W{1'b0}}, mag2} * {{TEMP_W{1'b0}}, off2};
    span3 <= span2;
    side3 <= side2;
  end

  // divide by code span
  logic              vq;
  logic [TEMP_W-1:0] quot;
  side_t             sideq;

  tti_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .dividend  (prod3),
    .divisor   (span3),
    .in_side   (side3),
    .out_valid (vq),
    .quotient  (quot),
    .out_side  (sideq)
  );

  // output stage: apply quotient to base temperature
  logic [TEMP_W-1:0] temp_next;

  always_comb begin
    if (sideq.pass) begin
      temp_next = sideq.base;
    end else if (sideq.up) begin
      temp_next = sideq.base + quot;
    end else begin
      temp_next = sideq.base - quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vq;
    end
  end

  always_ff @(posedge clk) begin
    temp_millideg <= temp_next;
    range_status  <= sideq.status;
  end

  // every accepted sample yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after accepted sample");

  // interpolated offset never exceeds its segment span
  a_segment: assert property (@(posedge clk) disable iff (rst)
    (v1 && st1 == ST_INTERP) |=> (off2 <= span2))
    else $error("sample outside selected segment");

  // clamped results carry the clamp temperatures
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    (done && range_status == ST_BELOW) |-> (temp_millideg == CLAMP_LOW_MDEG))
    else $error("below-range clamp value wrong");

  a_clamp_hi: assert property (@(posedge clk) disable iff (rst)
    (done && range_status == ST_ABOVE) |-> (temp_millideg == CLAMP_HIGH_MDEG))
    else $error("above-range clamp value wrong");

  // interpolated results stay within the calibrated temperatures
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    (done && range_status == ST_INTERP) |->
      (temp_millideg >= CAL_MDEG[0] && temp_millideg <= CAL_MDEG[CAL_LEN-1]))
    else $error("interpolated temperature out of table range");

endmodule

`default_nettype wire

### hdl/tti_divider.sv
// tti_divider: pipelined restoring divider, up to DIV_STEPS quotient bits per stage,
// with a sideband struct carried alongside. Depends on tti_pkg.
`default_nettype none

module tti_divider
  import tti_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [CODE_W-1:0] divisor,
  input  wire side_t             in_side,
  output logic                   out_valid,
  output logic [TEMP_W-1:0]      quotient,
  output side_t                  out_side
);

  // per-stage pipeline registers, index 0 is the input
  logic              vld  [DIV_STAGES+1];
  logic [CODE_W-1:0] rem  [DIV_STAGES+1];
  logic [TEMP_W-1:0] dvd  [DIV_STAGES+1];
  logic [TEMP_W-1:0] quo  [DIV_STAGES+1];
  logic [CODE_W-1:0] dsr  [DIV_STAGES+1];
  side_t             side [DIV_STAGES+1];

  // quotient fits TEMP_W bits, so the upper dividend bits start as remainder
  assign vld[0]  = in_valid;
  assign rem[0]  = dividend[PROD_W-1:TEMP_W];
  assign dvd[0]  = dividend[TEMP_W-1:0];
  assign quo[0]  = '0;
  assign dsr[0]  = divisor;
  assign side[0] = in_side;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    localparam int FIRST = s * DIV_STEPS;
    localparam int NSTEP = (TEMP_W - FIRST < DIV_STEPS) ? (TEMP_W - FIRST) : DIV_STEPS;

    logic [CODE_W-1:0] rem_c;
    logic [TEMP_W-1:0] dvd_c;
    logic [TEMP_W-1:0] quo_c;
    logic [CODE_W:0]   trial;

    // shift-compare-subtract steps of this stage
    always_comb begin
      rem_c = rem[s];
      dvd_c = dvd[s];
      quo_c = quo[s];
      trial = '0;
      for (int j = 0; j < NSTEP; j++) begin
        trial = {rem_c, dvd_c[TEMP_W-1]};
        dvd_c = {dvd_c[TEMP_W-2:0], 1'b0};
        if (trial >= {1'b0, dsr[s]}) begin
          trial = trial - {1'b0, dsr[s]};
          quo_c = {quo_c[TEMP_W-2:0], 1'b1};
        end else begin
          quo_c = {quo_c[TEMP_W-2:0], 1'b0};
        end
        rem_c = trial[CODE_W-1:0];
      end
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      rem[s+1]  <= rem_c;
      dvd[s+1]  <= dvd_c;
      quo[s+1]  <= quo_c;
      dsr[s+1]  <= dsr[s];
      side[s+1] <= side[s];
    end
  end

  assign out_valid = vld[DIV_STAGES];
  assign quotient  = quo[DIV_STAGES];
  assign out_side  = side[DIV_STAGES];

endmodule

`default_nettype wire

### tb/sv/tb_thermistor_table_interpolator.sv
// tb_thermistor_table_interpolator: self-checking bench for the thermistor table interpolator.
// Depends on tti_pkg for widths, the calibration table and status codes, and on the top level.
// A directed table of samples, then random samples, scored against a local predictor or a typed row's own result.
`default_nettype none

module tb_thermistor_table_interpolator;
  import tti_pkg::*;

  // expected temperature and status for one sample
  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    status_t           status;
  } temp_reading_t;

  // one row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    logic [CODE_W-1:0] reading;
    logic              typed;
    logic [TEMP_W-1:0] temp;
    status_t           status;
  } sample_row_t;

  localparam int NUM_DIRECTED = 20;
  localparam int NUM_RANDOM   = 1400;
  localparam int LATENCY      = 4 + DIV_STAGES;
  localparam int MAX_REPORTS  = 10;

  localparam sample_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{12'd0,    1'b1, 17'd93999, ST_ABOVE},
    '{12'd4095, 1'b1, 17'd11999, ST_BELOW},
    '{12'd2917, 1'b1, 17'd11999, ST_BELOW},
    '{12'd2918, 1'b1, 17'd11999, ST_BELOW},
    '{12'd613,  1'b1, 17'd93999, ST_ABOVE},
    '{12'd612,  1'b1, 17'd93999, ST_ABOVE},
    '{12'd1,    1'b1, 17'd93999, ST_ABOVE},
    '{12'd2916, 1'b0, 17'd0,     ST_INTERP},
    '{12'd614,  1'b0, 17'd0,     ST_INTERP},
    '{12'd2890, 1'b0, 17'd0,     ST_INTERP},
    '{12'd2569, 1'b0, 17'd0,     ST_INTERP},
    '{12'd2048, 1'b0, 17'd0,     ST_INTERP},
    '{12'd2047, 1'b0, 17'd0,     ST_INTERP},
    '{12'd1452, 1'b0, 17'd0,     ST_INTERP},
    '{12'd1140, 1'b0, 17'd0,     ST_INTERP},
    '{12'd703,  1'b0, 17'd0,     ST_INTERP},
    '{12'd2730, 1'b0, 17'd0,     ST_INTERP},
    '{12'd1365, 1'b0, 17'd0,     ST_INTERP},
    '{12'd2435, 1'b0, 17'd0,     ST_INTERP},
    '{12'd1000, 1'b0, 17'd0,     ST_INTERP}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [CODE_W-1:0]   adc_reading = '0;
  logic                busy;
  logic                done;
  logic [TEMP_W-1:0]   temp_millideg;
  logic [STATUS_W-1:0] range_status;

  temp_reading_t pending_temps [$];
  int            mismatches = 0;
  int            samples_sent = 0;
  int            results_checked = 0;
  int            interp_hits = 0;
  int            below_hits = 0;
  int            above_hits = 0;

  thermistor_table_interpolator u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .adc_reading  (adc_reading),
    .done         (done),
    .temp_millideg(temp_millideg),
    .range_status (range_status)
  );

  // clock, period 8
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // piecewise-linear lookup over the falling calibration codes
  function automatic temp_reading_t predict_temp(input logic [CODE_W-1:0] reading);
    temp_reading_t res;
    int unsigned   x;
    int unsigned   seg_span;
    int unsigned   seg_mag;
    int unsigned   quot;
    int unsigned   lo_temp;
    int unsigned   hi_temp;
    int            used_len;
    logic          found;
    x = 32'(reading) & ((32'd1 << DEF_ADC_BITS) - 32'd1);
    used_len = (DEF_TABLE_SIZE < 2) ? 2 : ((DEF_TABLE_SIZE < CAL_LEN) ? DEF_TABLE_SIZE : CAL_LEN);
    res.temp = TEMP_W'(93999);
    res.status = ST_ABOVE;
    found = 1'b0;
    if (x >= 32'(CAL_CODE[0])) begin
      res.temp = TEMP_W'(11999);
      res.status = ST_BELOW;
    end else if (x > 32'(CAL_CODE[used_len-1])) begin
      for (int k = 0; k + 1 < used_len; k++) begin
        if (!found && x <= 32'(CAL_CODE[k]) && x >= 32'(CAL_CODE[k+1])) begin
          found = 1'b1;
          lo_temp = 32'(CAL_MDEG[k+1]);
          hi_temp = 32'(CAL_MDEG[k]);
          seg_span = 32'(CAL_CODE[k]) - 32'(CAL_CODE[k+1]);
          res.status = ST_INTERP;
          if (seg_span == 0) begin
            res.temp = TEMP_W'(lo_temp);
          end else begin
            seg_mag = (hi_temp > lo_temp) ? hi_temp - lo_temp : lo_temp - hi_temp;
            quot = (seg_mag * (x - 32'(CAL_CODE[k+1]))) / seg_span;
            res.temp = (hi_temp > lo_temp) ? TEMP_W'(lo_temp + quot) : TEMP_W'(lo_temp - quot);
          end
        end
      end
    end
    return res;
  endfunction

  // offer one sample after an optional idle gap and hold it until the transaction completes
  task automatic apply_sample(input logic [CODE_W-1:0] reading, input int gap,
                              input logic typed, input temp_reading_t typed_exp);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    adc_reading <= reading;
    do @(posedge clk); while (busy);
    pending_temps.push_back(typed ? typed_exp : predict_temp(reading));
    samples_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_temps.size() != 0);
  endtask

  // result checker, one transaction per done cycle
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_temps.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: temp %0d status %0d", temp_millideg, range_status);
        mismatches++;
      end else begin
        temp_reading_t exp_res;
        exp_res = pending_temps.pop_front();
        results_checked++;
        case (exp_res.status)
          ST_INTERP: interp_hits++;
          ST_BELOW:  below_hits++;
          default:   above_hits++;
        endcase
        if (temp_millideg !== exp_res.temp || range_status !== exp_res.status) begin
          if (mismatches < MAX_REPORTS)
            $display("mismatch: expected temp %0d status %0d, got temp %0d status %0d",
                     exp_res.temp, exp_res.status, temp_millideg, range_status);
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int            gap;
    int            idle_mode;
    int            pick;
    int            code;
    temp_reading_t typed_exp;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      typed_exp.temp = DIRECTED_ROWS[r].temp;
      typed_exp.status = DIRECTED_ROWS[r].status;
      gap = (r < 8) ? 0 : $urandom_range(0, 5);
      apply_sample(DIRECTED_ROWS[r].reading, gap, DIRECTED_ROWS[r].typed, typed_exp);
    end
    drain_results();

    // random samples, idle pattern redrawn every hundred
    typed_exp = '0;
    idle_mode = 0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 100 == 0)
        idle_mode = $urandom_range(0, 2);
      if (i == NUM_RANDOM / 2)
        drain_results();
      case (idle_mode)
        0:       gap = 0;
        1:       gap = $urandom_range(0, 5);
        default: gap = ($urandom_range(0, 7) == 0) ? 5 : 0;
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        code = $urandom_range(614, 2916);
      end else if (pick < 8) begin
        code = CAL_CODE[$urandom_range(0, CAL_LEN-1)] + $urandom_range(0, 2) - 1;
      end else begin
        code = $urandom_range(0, 4095);
      end
      apply_sample(CODE_W'(code), gap, 1'b0, typed_exp);
    end

    drain_results();
    repeat (LATENCY + 4) @(posedge clk);
    $display("sent %0d samples, checked %0d results", samples_sent, results_checked);
    $display("interpolated %0d, clamped cold %0d, clamped hot %0d",
             interp_hits, below_hits, above_hits);
    if (mismatches == 0 && pending_temps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1600000;
    $display("timeout waiting for results");
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

### thermistor_table_interpolator.f
hdl/tti_pkg.sv
hdl/tti_divider.sv
hdl/thermistor_table_interpolator.sv
tb/sv/tb_thermistor_table_interpolator.sv
